[hw/rtl/bls_pkg.sv]
// Package for the book level sweep block: widths, item kinds, controller
// command and status structs. No dependencies.
`timescale 1ns / 1ps
package bls_pkg;
	localparam int LEVEL_DEPTH = 32;
	localparam int IDX_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

	localparam logic [1:0] KIND_TRADE  = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_APPEND = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	typedef struct packed {
		logic load;     // capture input word
		logic clear;    // empty both sides
		logic append;   // store level at count
		logic sweep;    // fetch next level, process the one fetched before
		logic finish;   // commit count, write result
	} bls_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       more;   // levels left to fetch or one still in flight
	} bls_stat_t;
endpackage

[hw/rtl/book_level_sweep.sv]
// Top level of the price-level book sweep: controller plus datapath.
// Throughput: one word at a time; the next word is taken no earlier than the cycle the
// result leaves.
// The sweep fetches one level per cycle from the level store, compacting in the same pass.
// Reset: arst_n clears both side counts and the handshake state.
`timescale 1ns / 1ps
module book_level_sweep (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // kind[1:0], price_tick[33:2], quantity[65:34]
	input  logic         s_tuser,   // side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // status, taken_qty, better_price_qty,
	                                // unfilled_qty, no_liquidity
);
	import bls_pkg::*;

	bls_cmd_t  cmd;
	bls_stat_t stat;
	logic [97:0] res;

	bls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_taken(m_tvalid && m_tready), .stat(stat), .cmd(cmd),
		.in_ready(s_tready), .out_valid(m_tvalid)
	);

	bls_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(s_tdata[65:0]), .in_side(s_tuser),
		.cmd(cmd), .stat(stat), .res_word(res)
	);

	assign m_tdata = {6'd0, res};
endmodule

[hw/rtl/bls_datapath.sv]
// Datapath: level memories, sweep/compact pointers, accumulators, result
// register. Depends on bls_pkg.
`timescale 1ns / 1ps
module bls_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [65:0]      in_word,
	input  logic             in_side,
	input  bls_pkg::bls_cmd_t cmd,
	output bls_pkg::bls_stat_t stat,
	output logic [97:0]      res_word
);
	import bls_pkg::*;

	logic [31:0] px_mem [2][LEVEL_DEPTH];
	logic [31:0] qt_mem [2][LEVEL_DEPTH];
	logic [CNT_W-1:0] cnt_q [2];
	logic [1:0]  kind_q;
	logic        side_q;
	logic [31:0] price_q, left_q, matched_q, better_q;
	logic        stop_q;
	logic        drop_q;
	logic [CNT_W-1:0] rd_q, wr_q;
	logic [31:0] px_s1, qt_s1;
	logic        lvl_vld_s1;
	logic        bs; // book side touched: append uses side, trade the opposite
	logic [31:0] take, rem_qt;
	logic        crosses, active;

	assign bs = (kind_q == KIND_APPEND) ? side_q : ~side_q;
	assign crosses = side_q ? (px_s1 >= price_q) : (px_s1 <= price_q);
	assign active = lvl_vld_s1 && !stop_q && left_q != '0 && crosses;
	assign take = !active ? '0 : ((left_q < qt_s1) ? left_q : qt_s1);
	assign rem_qt = qt_s1 - take;
	assign stat.kind = kind_q;
	assign stat.more = (rd_q < cnt_q[bs]) || lvl_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (cmd.clear) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (cmd.append && cnt_q[bs] < CNT_W'(LEVEL_DEPTH)) begin
			cnt_q[bs] <= cnt_q[bs] + 1'b1;
		end else if (cmd.finish && kind_q == KIND_TRADE) begin
			cnt_q[bs] <= wr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_word[1:0];
			side_q <= in_side;
			price_q <= in_word[33:2];
			left_q <= in_word[65:34];
			matched_q <= '0;
			better_q <= '0;
			stop_q <= 1'b0;
			drop_q <= 1'b0;
			lvl_vld_s1 <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
		end
		if (cmd.append) begin
			drop_q <= cnt_q[bs] >= CNT_W'(LEVEL_DEPTH);
			if (cnt_q[bs] < CNT_W'(LEVEL_DEPTH)) begin
				px_mem[bs][cnt_q[bs][IDX_W-1:0]] <= price_q;
				qt_mem[bs][cnt_q[bs][IDX_W-1:0]] <= left_q;
			end
		end
		if (cmd.sweep) begin
			// fetch the next level while the one fetched last cycle is processed
			if (rd_q < cnt_q[bs]) begin
				px_s1 <= px_mem[bs][rd_q[IDX_W-1:0]];
				qt_s1 <= qt_mem[bs][rd_q[IDX_W-1:0]];
				rd_q <= rd_q + 1'b1;
				lvl_vld_s1 <= 1'b1;
			end else begin
				lvl_vld_s1 <= 1'b0;
			end
			if (lvl_vld_s1) begin
				// stop at first non-crossing level; compact as we go
				if (!stop_q && left_q != '0 && !crosses) stop_q <= 1'b1;
				left_q <= left_q - take;
				matched_q <= matched_q + take;
				if (px_s1 != price_q) better_q <= better_q + take;
				if (rem_qt != '0) begin
					px_mem[bs][wr_q[IDX_W-1:0]] <= px_s1;
					qt_mem[bs][wr_q[IDX_W-1:0]] <= rem_qt;
					wr_q <= wr_q + 1'b1;
				end
			end
		end
		if (cmd.finish) begin
			if (kind_q == KIND_TRADE)
				res_word <= {matched_q == '0, left_q, better_q, matched_q, 1'b0};
			else if (kind_q == KIND_APPEND)
				res_word <= {97'd0, drop_q};
			else
				res_word <= '0;
		end
	end
endmodule

[hw/rtl/bls_ctrl.sv]
// Controller: sequences load, append/clear, sweep and result handoff.
// Depends on bls_pkg.
`timescale 1ns / 1ps
module bls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_taken,
	input  bls_pkg::bls_stat_t stat,
	output bls_pkg::bls_cmd_t cmd,
	output logic              in_ready,
	output logic              out_valid
);
	import bls_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic   ov_q;

	assign out_valid = ov_q;
	assign in_ready = (state_q == ST_IDLE) && (!ov_q || out_taken);

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		unique case (state_q)
			ST_EXEC: begin
				cmd.clear = stat.kind == KIND_CLEAR;
				cmd.append = stat.kind == KIND_APPEND;
			end
			ST_SWEEP: cmd.sweep = stat.more;
			ST_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (out_taken) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_EXEC;
				ST_EXEC: state_q <= (stat.kind == KIND_TRADE) ? ST_SWEEP : ST_DONE;
				ST_SWEEP: if (!stat.more) state_q <= ST_DONE;
				ST_DONE: begin
					ov_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[bench/tb_book_level_sweep.sv]
// Testbench for book_level_sweep: drives clear, append, trade and unused-kind words and
// checks every result word against an in-bench book model.
// Depends on bls_pkg and the book_level_sweep RTL.
`timescale 1ns / 1ps
module tb_book_level_sweep;
	import bls_pkg::*;

	typedef struct packed {
		logic        no_liquidity;
		logic [31:0] unfilled_qty;
		logic [31:0] better_price_qty;
		logic [31:0] taken_qty;
		logic        status;
	} book_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;   // kind[1:0], price_tick[33:2], quantity[65:34]
	logic         s_tuser;   // side
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // status, taken_qty, better_price_qty, unfilled_qty, no_liquidity

	book_level_sweep i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow book, index 0 of a side is side 0 (bids), 1 (asks)
	logic [31:0] lvl_px [2][LEVEL_DEPTH];
	logic [31:0] lvl_qt [2][LEVEL_DEPTH];
	int          lvl_cnt [2];
	book_result_t pending_results[$];
	int          errors = 0;
	int          burst_left = 0;
	logic [31:0] ref_px;

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	function automatic book_result_t apply_word(logic [1:0] kind, logic side,
			logic [31:0] px, logic [31:0] qty);
		book_result_t r;
		int b, wr;
		logic [31:0] left, take;
		logic hit;
		r = '0;
		if (kind == KIND_CLEAR) begin
			lvl_cnt[0] = 0;
			lvl_cnt[1] = 0;
		end else if (kind == KIND_APPEND) begin
			if (lvl_cnt[side] >= LEVEL_DEPTH) r.status = 1'b1;
			else begin
				lvl_px[side][lvl_cnt[side]] = px;
				lvl_qt[side][lvl_cnt[side]] = qty;
				lvl_cnt[side]++;
			end
		end else if (kind == KIND_TRADE) begin
			b = side ? 0 : 1;   // buyer hits asks, seller hits bids
			left = qty;
			for (int i = 0; i < lvl_cnt[b] && left != 0; i++) begin
				hit = side ? (lvl_px[b][i] >= px) : (lvl_px[b][i] <= px);
				if (!hit) break;
				take = (left < lvl_qt[b][i]) ? left : lvl_qt[b][i];
				lvl_qt[b][i] -= take;
				left -= take;
				r.taken_qty += take;
				if (lvl_px[b][i] != px) r.better_price_qty += take;
			end
			wr = 0;
			for (int i = 0; i < lvl_cnt[b]; i++) begin
				if (lvl_qt[b][i] != 0) begin
					lvl_px[b][wr] = lvl_px[b][i];
					lvl_qt[b][wr] = lvl_qt[b][i];
					wr++;
				end
			end
			lvl_cnt[b] = wr;
			r.unfilled_qty = left;
			r.no_liquidity = (r.taken_qty == 0);
		end
		return r;
	endfunction

	task automatic send_word(logic [1:0] kind, logic side, logic [31:0] px, logic [31:0] qty);
		int gap_n;
		// bursts with random gaps
		if (burst_left == 0) begin
			gap_n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
			if (gap_n > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap_n) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, qty, px, kind};
		s_tuser  <= side;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.insert(pending_results.size(), apply_word(kind, side, px, qty));
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		case ($urandom_range(0, 3))
			0: m_tready <= ($urandom_range(0, 9) == 0);
			1: m_tready <= 1'b1;
			default: m_tready <= ($urandom_range(0, 2) != 0);
		endcase
	end

	always @(posedge clk) begin
		book_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[97:0];
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected, actual %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected st=%0d m=%0d b=%0d u=%0d nl=%0d",
						$realtime, want.status, want.taken_qty, want.better_price_qty,
						want.unfilled_qty, want.no_liquidity);
					$display("%0t:          actual st=%0d m=%0d b=%0d u=%0d nl=%0d",
						$realtime, got.status, got.taken_qty, got.better_price_qty,
						got.unfilled_qty, got.no_liquidity);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 4);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_word(KIND_TRADE, 1'b0, 32'hFFFF_FFFF, 32'd10);   // empty book
		send_word(KIND_APPEND, 1'b1, 32'd100, 32'd5);
		send_word(KIND_APPEND, 1'b1, 32'd101, 32'd0);           // zero-quantity level
		send_word(KIND_APPEND, 1'b1, 32'd99, 32'hFFFF_FFFF);    // out of price order
		send_word(KIND_APPEND, 1'b1, 32'd200, 32'd7);
		send_word(KIND_TRADE, 1'b0, 32'd101, 32'd0);            // zero trade, compacts
		send_word(KIND_TRADE, 1'b0, 32'd101, 32'd8);
		send_word(KIND_TRADE, 1'b0, 32'd0, 32'hFFFF_FFFF);
		send_word(KIND_APPEND, 1'b0, 32'hFFFF_FFFF, 32'd3);
		send_word(KIND_APPEND, 1'b0, 32'd0, 32'd4);
		send_word(KIND_TRADE, 1'b1, 32'd0, 32'hFFFF_FFFF);
		send_word(KIND_RSVD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused kind
		send_word(KIND_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_side_full();
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < LEVEL_DEPTH + 2; i++)
				send_word(KIND_APPEND, s[0], $urandom, $urandom_range(1, 9));
		send_word(KIND_TRADE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(KIND_TRADE, 1'b1, 32'h0, 32'hFFFF_FFFF);
		send_word(KIND_CLEAR, 1'b0, 32'h0, 32'h0);
	endtask

	task automatic test_random_book();
		logic side;
		int   n;
		for (int k = 0; k < 1050; ) begin
			case ($urandom_range(0, 19))
				0: begin
					send_word(KIND_CLEAR, 1'($urandom), rand_word(), rand_word());
					k++;
				end
				1: begin
					send_word(2'($urandom_range(0, 3)), 1'($urandom), rand_word(),
						rand_word());
					k++;
				end
				2, 3, 4, 5, 6, 7, 8: begin
					// ladder of levels near a reference price
					side = 1'($urandom);
					n = $urandom_range(1, 8);
					ref_px = (side ? 32'd1000 : 32'd1010);
					for (int i = 0; i < n; i++) begin
						send_word(KIND_APPEND, side,
							side ? ref_px + i : ref_px - i, $urandom_range(0, 50));
						k++;
					end
				end
				default: begin
					side = 1'($urandom);
					send_word(KIND_TRADE, side, $urandom_range(0, 5) == 0 ? rand_word() :
						32'd995 + $urandom_range(0, 20), $urandom_range(0, 5) == 0 ?
						rand_word() : $urandom_range(0, 120));
					k++;
				end
			endcase
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		lvl_cnt[0] = 0;
		lvl_cnt[1] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_side_full();
		test_random_book();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_book_level_sweep: clean");
		else
			$display("tb_book_level_sweep: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_book_level_sweep: errors");
		$finish;
	end
endmodule
